// ----- design/rbn_pkg.sv -----
`default_nettype none

package rbn_pkg;

  localparam int unsigned WordBits      = 32;
  localparam int unsigned ByteBits      = 8;
  localparam int unsigned PrecisionBits = 12;
  localparam int unsigned WidthShift    = PrecisionBits - 1;
  localparam int unsigned StepBits      = $clog2(WordBits);

  localparam logic [WordBits-1:0] WidthFloor = WordBits'(64'd1 << (WordBits - 1 - ByteBits));
  localparam logic [WordBits-1:0] InitWidth  = WordBits'(64'd1 << (ByteBits - 1));

  localparam int unsigned SymLowBits  = 12;
  localparam int unsigned SymFreqBits = 13;
  localparam int unsigned TargetBits  = 16;

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_FEED   = 2'd1,
    OP_DECODE = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ----- design/rbn_div.sv -----
`default_nettype none

module rbn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbn_pkg::div_req_t req_i,
  output logic              done_o,
  output rbn_pkg::word_t    quotient_o
);

  logic                          busy_q, busy_d;
  logic [rbn_pkg::StepBits-1:0]  cnt_q, cnt_d;
  rbn_pkg::word_t                rem_q, rem_d;
  rbn_pkg::word_t                quo_q, quo_d;
  rbn_pkg::word_t                div_q, div_d;
  logic [rbn_pkg::WordBits:0]    trial;
  logic [rbn_pkg::WordBits:0]    diff;
  logic                          last_step;

  assign trial     = {rem_q, quo_q[rbn_pkg::WordBits-1]};
  assign diff      = trial - {1'b0, div_q};
  assign last_step = (cnt_q == rbn_pkg::StepBits'(rbn_pkg::WordBits - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = diff[rbn_pkg::WordBits] ? trial[rbn_pkg::WordBits-1:0]
                                      : diff[rbn_pkg::WordBits-1:0];
      quo_d = {quo_q[rbn_pkg::WordBits-2:0], ~diff[rbn_pkg::WordBits]};
      cnt_d = cnt_q + rbn_pkg::StepBits'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = busy_q && last_step;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- design/range_decoder_byte_normalized_unit.sv -----
`default_nettype none

// byte-oriented range decoder holding a 32-bit low value and a 32-bit width.
// input tuser carries the operation: init, feed byte, decode, update. update
// uses one shared 32x13 multiplier (width times cumulative low, then width
// times frequency). decode with width at most 2^23 answers need_byte;
// otherwise the width is scaled down and low is divided by it in a restoring
// divider that retires one quotient bit per cycle. a decode runs through the
// transfer, 32 divider steps and the load of the output register once that is
// free. the block takes no new item while an operation is under way; a result
// may wait in the output register while init, feed and update items keep
// being taken.
module range_decoder_byte_normalized_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // code_byte [7:0], sym_low [19:8], sym_freq [32:20], zero fill [39:33]
  input  logic [39:0] s_axis_tdata,
  // op [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // target [15:0]
  output logic [15:0] m_axis_tdata,
  // need_byte [0]
  output logic        m_axis_tuser
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV     = 6'b000010,
    ST_OUT     = 6'b000100,
    ST_MUL_LOW = 6'b001000,
    ST_MUL_WID = 6'b010000,
    ST_UPD_WID = 6'b100000
  } state_e;

  state_e state_q, state_d;

  rbn_pkg::word_t low_q, low_d;
  rbn_pkg::word_t width_q, width_d;
  rbn_pkg::word_t prod_q, prod_d;
  logic [rbn_pkg::SymLowBits-1:0]  sym_low_q, sym_low_d;
  logic [rbn_pkg::SymFreqBits-1:0] sym_freq_q, sym_freq_d;
  logic need_q, need_d;

  logic                             out_valid_q, out_valid_d;
  logic [rbn_pkg::TargetBits-1:0]   out_target_q, out_target_d;
  logic                             out_need_q, out_need_d;

  rbn_pkg::op_e                     op;
  logic [rbn_pkg::ByteBits-1:0]     code_byte;
  logic                             in_xfer;
  logic                             out_free;
  rbn_pkg::word_t                   width_scaled;
  logic [rbn_pkg::SymFreqBits-1:0]  mul_b;
  logic [rbn_pkg::WordBits+rbn_pkg::SymFreqBits-1:0] mul_full;

  rbn_pkg::div_req_t div_req;
  logic              div_done;
  rbn_pkg::word_t    div_quo;

  assign op        = rbn_pkg::op_e'(s_axis_tuser);
  assign code_byte = s_axis_tdata[7:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  assign width_scaled = width_q >> rbn_pkg::WidthShift;

  assign mul_b    = (state_q == ST_MUL_LOW) ? {1'b0, sym_low_q} : sym_freq_q;
  assign mul_full = {{rbn_pkg::SymFreqBits{1'b0}}, width_q}
                  * {{rbn_pkg::WordBits{1'b0}}, mul_b};

  always_comb begin
    state_d      = state_q;
    low_d        = low_q;
    width_d      = width_q;
    prod_d       = prod_q;
    sym_low_d    = sym_low_q;
    sym_freq_d   = sym_freq_q;
    need_d       = need_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_target_d = out_target_q;
    out_need_d   = out_need_q;
    div_req      = '{start: 1'b0, dividend: low_q, divisor: width_scaled};

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (op)
            rbn_pkg::OP_INIT: begin
              width_d = rbn_pkg::InitWidth;
              low_d   = {{(rbn_pkg::WordBits-rbn_pkg::ByteBits){1'b0}}, code_byte};
            end
            rbn_pkg::OP_FEED: begin
              low_d   = {low_q[rbn_pkg::WordBits-rbn_pkg::ByteBits-1:0], code_byte};
              width_d = {width_q[rbn_pkg::WordBits-rbn_pkg::ByteBits-1:0],
                         {rbn_pkg::ByteBits{1'b0}}};
            end
            rbn_pkg::OP_DECODE: begin
              if (width_q <= rbn_pkg::WidthFloor) begin
                need_d  = 1'b1;
                state_d = ST_OUT;
              end else begin
                need_d        = 1'b0;
                width_d       = width_scaled;
                div_req.start = 1'b1;
                state_d       = ST_DIV;
              end
            end
            rbn_pkg::OP_UPDATE: begin
              sym_low_d  = s_axis_tdata[19:8];
              sym_freq_d = s_axis_tdata[32:20];
              state_d    = ST_MUL_LOW;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_need_d   = need_q;
          out_target_d = need_q ? '0 : div_quo[rbn_pkg::TargetBits-1:0];
          state_d      = ST_IDLE;
        end
      end
      ST_MUL_LOW: begin
        prod_d  = mul_full[rbn_pkg::WordBits-1:0];
        state_d = ST_MUL_WID;
      end
      ST_MUL_WID: begin
        low_d   = low_q - prod_q;
        prod_d  = mul_full[rbn_pkg::WordBits-1:0];
        state_d = ST_UPD_WID;
      end
      ST_UPD_WID: begin
        width_d = {1'b0, prod_q[rbn_pkg::WordBits-1:1]};
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= '0;
      width_q     <= rbn_pkg::InitWidth;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      width_q     <= width_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    sym_low_q    <= sym_low_d;
    sym_freq_q   <= sym_freq_d;
    need_q       <= need_d;
    out_target_q <= out_target_d;
    out_need_q   <= out_need_d;
  end

  rbn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_target_q;
  assign m_axis_tuser  = out_need_q;

endmodule

`default_nettype wire
